>>> rtl/sdq_pkg.sv
// Shared types, codes and the critical value tables for the sliding Dixon Q outlier core.
// Depends on nothing; imported by the scan, test and top-level modules.
package sdq_pkg;

	// Confidence selector codes
	localparam logic [1:0] CONF_90 = 2'd0;
	localparam logic [1:0] CONF_95 = 2'd1;
	localparam logic [1:0] CONF_99 = 2'd2;

	// Verdict codes
	localparam logic [1:0] VERDICT_NONE = 2'd0;
	localparam logic [1:0] VERDICT_LOW  = 2'd1;
	localparam logic [1:0] VERDICT_HIGH = 2'd2;

	// Critical values are in thousandths
	localparam logic [9:0] Q_SCALE = 10'd1000;
	localparam int CRIT_ENTRIES = 28;

	localparam logic [9:0] CRIT90 [CRIT_ENTRIES] = '{
		10'd941, 10'd765, 10'd642, 10'd560, 10'd507, 10'd468, 10'd437, 10'd412,
		10'd392, 10'd376, 10'd361, 10'd349, 10'd338, 10'd329, 10'd320, 10'd313,
		10'd306, 10'd300, 10'd295, 10'd290, 10'd285, 10'd281, 10'd277, 10'd273,
		10'd269, 10'd266, 10'd263, 10'd260
	};
	localparam logic [9:0] CRIT95 [CRIT_ENTRIES] = '{
		10'd970, 10'd829, 10'd710, 10'd625, 10'd568, 10'd526, 10'd493, 10'd466,
		10'd444, 10'd426, 10'd410, 10'd396, 10'd384, 10'd374, 10'd365, 10'd356,
		10'd349, 10'd342, 10'd337, 10'd331, 10'd326, 10'd321, 10'd317, 10'd312,
		10'd308, 10'd305, 10'd301, 10'd290
	};
	localparam logic [9:0] CRIT99 [CRIT_ENTRIES] = '{
		10'd994, 10'd926, 10'd821, 10'd740, 10'd680, 10'd634, 10'd598, 10'd568,
		10'd542, 10'd522, 10'd503, 10'd488, 10'd475, 10'd463, 10'd452, 10'd442,
		10'd433, 10'd425, 10'd418, 10'd411, 10'd404, 10'd399, 10'd393, 10'd388,
		10'd384, 10'd380, 10'd376, 10'd372
	};

	// Index is window size minus three; an unused selector code reads as 99 percent
	function automatic logic [9:0] crit_lookup(input logic [4:0] idx, input logic [1:0] conf);
		logic [9:0] val;
		case (conf)
			CONF_90: val = CRIT90[idx];
			CONF_95: val = CRIT95[idx];
			default: val = CRIT99[idx];
		endcase
		return val;
	endfunction

	// Scan control travelling alongside the window read data
	typedef struct packed {
		logic vld;
		logic first;
		logic last;
	} scan_ctl_t;

endpackage

>>> rtl/sdq_window_ram.sv
// Window sample store: one write port, one read port, registered read data.
// Standalone; no package dependency.
module sdq_window_ram #(
	parameter int DEPTH = 8,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> rtl/sdq_extrema.sv
// Running tracker of the two smallest and two largest window samples.
// Depends on sdq_pkg for the scan control struct.
module sdq_extrema #(
	parameter int DW = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sdq_pkg::scan_ctl_t   ctl,
	input  logic signed [DW-1:0] smp,
	output logic signed [DW-1:0] min1,
	output logic signed [DW-1:0] min2,
	output logic signed [DW-1:0] max1,
	output logic signed [DW-1:0] max2,
	output logic                 done
);
	import sdq_pkg::*;

	localparam logic signed [DW-1:0] POS_MAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] NEG_MIN = {1'b1, {(DW-1){1'b0}}};

	logic signed [DW-1:0] min1_q, min2_q, max1_q, max2_q;
	logic                 done_q;

	always_ff @(posedge clk) begin
		if (ctl.vld) begin
			if (ctl.first) begin
				min1_q <= smp;
				max1_q <= smp;
				min2_q <= POS_MAX;
				max2_q <= NEG_MIN;
			end else begin
				// Ties fall to the second slot, so duplicates count twice
				if (smp < min1_q) begin
					min1_q <= smp;
					min2_q <= min1_q;
				end else if (smp < min2_q) begin
					min2_q <= smp;
				end
				if (smp > max1_q) begin
					max1_q <= smp;
					max2_q <= max1_q;
				end else if (smp > max2_q) begin
					max2_q <= smp;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl.vld & ctl.last;
		end
	end

	assign min1 = min1_q;
	assign min2 = min2_q;
	assign max1 = max1_q;
	assign max2 = max2_q;
	assign done = done_q;

endmodule

>>> rtl/sdq_qtest.sv
// Three-stage Dixon Q decision: gaps and range, cross products, compare.
// Depends on sdq_pkg for the scale constant and verdict codes.
module sdq_qtest #(
	parameter int DW = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [DW-1:0] min1,
	input  logic signed [DW-1:0] min2,
	input  logic signed [DW-1:0] max1,
	input  logic signed [DW-1:0] max2,
	input  logic [9:0]           crit,
	output logic                 done,
	output logic [1:0]           verdict
);
	import sdq_pkg::*;

	localparam int PW = DW + 10;

	logic signed [DW:0] lo_diff, hi_diff, rng_diff;
	logic [DW-1:0] lo_gap_s1, hi_gap_s1, rng_s1;
	logic [9:0]    crit_s1;
	logic [PW-1:0] lo_prod_s2, hi_prod_s2, rhs_s2;
	logic          nz_s2;
	logic          vld_s1, vld_s2, done_q;
	logic [1:0]    verdict_q;

	// Differences of ordered samples are never negative and fit DW bits
	assign lo_diff  = {min2[DW-1], min2} - {min1[DW-1], min1};
	assign hi_diff  = {max1[DW-1], max1} - {max2[DW-1], max2};
	assign rng_diff = {max1[DW-1], max1} - {min1[DW-1], min1};

	always_ff @(posedge clk) begin
		lo_gap_s1  <= lo_diff[DW-1:0];
		hi_gap_s1  <= hi_diff[DW-1:0];
		rng_s1     <= rng_diff[DW-1:0];
		crit_s1    <= crit;
		lo_prod_s2 <= PW'(lo_gap_s1) * PW'(Q_SCALE);
		hi_prod_s2 <= PW'(hi_gap_s1) * PW'(Q_SCALE);
		rhs_s2     <= PW'(rng_s1) * PW'(crit_s1);
		nz_s2      <= (rng_s1 != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			done_q    <= 1'b0;
			verdict_q <= VERDICT_NONE;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			done_q <= vld_s2;
			if (vld_s2) begin
				// High outlier wins over low; a flat window flags nothing
				if (nz_s2 && (hi_prod_s2 > rhs_s2)) begin
					verdict_q <= VERDICT_HIGH;
				end else if (nz_s2 && (lo_prod_s2 > rhs_s2)) begin
					verdict_q <= VERDICT_LOW;
				end else begin
					verdict_q <= VERDICT_NONE;
				end
			end
		end
	end

	assign done    = done_q;
	assign verdict = verdict_q;

endmodule

>>> rtl/sliding_dixon_q_outlier_core.sv
// Sliding-window Dixon Q outlier core: window memory, extrema scan and Q test.
// Depends on sdq_pkg, sdq_window_ram, sdq_extrema and sdq_qtest.
// Path from input transaction to tvalid high: window not yet full, intake then output load;
//   window full, one memory read per entry, one extrema update, three Q test
//   stages, result capture, output load.
// Flow: a sample is accepted only in the idle state, so each one is handled before the next;
//   the output register lets a new sample in while a result waits, and a second result holds
//   the sequencer until the first is taken.
// Reset (arst_n low, asynchronous): empties the window, rewinds the write pointer,
//   confidence goes to 95 percent; window contents stay unknown until written.
module sliding_dixon_q_outlier_core #(
	parameter int WINDOW_SIZE  = 8,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_data,      // [1:0] confidence_select
	// Sample stream in
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [15:0] sample (signed)
	// Verdict stream out
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata   // [1:0] verdict, [7:2] zero
);
	import sdq_pkg::*;

	localparam int AW = $clog2(WINDOW_SIZE);
	localparam int DW = SAMPLE_WIDTH;
	localparam logic [AW-1:0] LAST_IDX = AW'(WINDOW_SIZE - 1);
	localparam logic [4:0]    CRIT_IDX = 5'(WINDOW_SIZE - 3);

	// Control states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_TEST = 2'd2;
	localparam logic [1:0] ST_HOLD = 2'd3;

	logic [1:0]    state_q;
	logic [AW-1:0] wp_q;
	logic          full_q;
	logic [AW-1:0] rd_cnt_q;
	logic [1:0]    conf_q;
	logic [1:0]    result_q;
	logic          m_vld_q;
	logic [1:0]    verdict_q;

	logic          s_acc;
	logic          wrap;
	logic          rd_en;
	logic [DW-1:0] smp_ext;
	logic [DW-1:0] rd_data;
	scan_ctl_t     ctl_s1;

	logic signed [DW-1:0] min1, min2, max1, max2;
	logic       ext_done;
	logic       qt_done;
	logic [1:0] qt_verdict;
	logic       out_free;

	// ------------------------------------------------------------------
	// Configuration: always ready, hold the selected confidence level
	// ------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conf_q <= CONF_95;
		end else if (cfg_valid) begin
			conf_q <= cfg_data;
		end
	end

	// ------------------------------------------------------------------
	// Sample intake: narrow samples take the low SAMPLE_WIDTH bits as they are,
	// wider internal words take the 16-bit field as an unsigned value
	// ------------------------------------------------------------------
	generate
		if (SAMPLE_WIDTH <= 16) begin : g_narrow
			assign smp_ext = s_axis_tdata[SAMPLE_WIDTH-1:0];
		end else begin : g_wide
			assign smp_ext = {{(SAMPLE_WIDTH-16){1'b0}}, s_axis_tdata};
		end
	endgenerate

	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_acc         = s_axis_tvalid & s_axis_tready;
	assign wrap          = (wp_q == LAST_IDX);

	// ------------------------------------------------------------------
	// Window memory: write on intake, read one entry per cycle on scan.
	// A scan always starts the cycle after the write, so no forwarding.
	// ------------------------------------------------------------------
	assign rd_en = (state_q == ST_SCAN);

	sdq_window_ram #(
		.DEPTH (WINDOW_SIZE),
		.WIDTH (DW)
	) u_ram (
		.clk     (clk),
		.wr_en   (s_acc),
		.wr_addr (wp_q),
		.wr_data (smp_ext),
		.rd_en   (rd_en),
		.rd_addr (rd_cnt_q),
		.rd_data (rd_data)
	);

	// Scan control is registered alongside the memory read, so it lines up with the read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.vld   <= rd_en;
			ctl_s1.first <= (rd_cnt_q == '0);
			ctl_s1.last  <= (rd_cnt_q == LAST_IDX);
		end
	end

	sdq_extrema #(
		.DW (DW)
	) u_extrema (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl_s1),
		.smp    (rd_data),
		.min1   (min1),
		.min2   (min2),
		.max1   (max1),
		.max2   (max2),
		.done   (ext_done)
	);

	sdq_qtest #(
		.DW (DW)
	) u_qtest (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (ext_done),
		.min1    (min1),
		.min2    (min2),
		.max1    (max1),
		.max2    (max2),
		.crit    (crit_lookup(CRIT_IDX, conf_q)),
		.done    (qt_done),
		.verdict (qt_verdict)
	);

	// ------------------------------------------------------------------
	// Sequencer: intake, scan, wait for the test, hand off the result
	// ------------------------------------------------------------------
	assign out_free = !m_vld_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			wp_q     <= '0;
			full_q   <= 1'b0;
			rd_cnt_q <= '0;
			result_q <= VERDICT_NONE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						wp_q     <= wrap ? '0 : wp_q + 1'b1;
						full_q   <= full_q | wrap;
						rd_cnt_q <= '0;
						result_q <= VERDICT_NONE;
						// Skip the test until every entry has been written
						state_q  <= (full_q | wrap) ? ST_SCAN : ST_HOLD;
					end
				end
				ST_SCAN: begin
					if (rd_cnt_q == LAST_IDX) begin
						rd_cnt_q <= '0;
						state_q  <= ST_TEST;
					end else begin
						rd_cnt_q <= rd_cnt_q + 1'b1;
					end
				end
				ST_TEST: begin
					if (qt_done) begin
						result_q <= qt_verdict;
						state_q  <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Output register: load from HOLD, drop once the transaction completes
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_vld_q   <= 1'b0;
			verdict_q <= VERDICT_NONE;
		end else if (state_q == ST_HOLD && out_free) begin
			m_vld_q   <= 1'b1;
			verdict_q <= result_q;
		end else if (m_axis_tready) begin
			m_vld_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = m_vld_q;
	assign m_axis_tdata  = {6'b0, verdict_q};

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_full_scans: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && (full_q || wrap) |=> state_q == ST_SCAN)
		else $error("full window intake did not start a scan");

	a_test_done_in_test: assert property (@(posedge clk) disable iff (!arst_n)
		qt_done |-> state_q == ST_TEST)
		else $error("Q test finished outside the test state");

	a_verdict_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_vld_q |-> (verdict_q == VERDICT_NONE || verdict_q == VERDICT_LOW ||
			verdict_q == VERDICT_HIGH))
		else $error("illegal verdict code on output");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> rd_cnt_q <= LAST_IDX)
		else $error("scan read index beyond window");

	a_wp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wp_q <= LAST_IDX)
		else $error("write pointer beyond window");

endmodule
